// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; LPI_ASSERT uses clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: label, clock, active-low reset, property
`define LPI_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// default clock and reset
`define LPI_ASSERT(lbl, prop) `LPI_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and constants of the line/plane intersection core.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PX = 3'd0,
    REG_PY = 3'd1,
    REG_PZ = 3'd2,
    REG_NX = 3'd3,
    REG_NY = 3'd4,
    REG_NZ = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/lpi_div.sv =====
// ----------------------------------------------------------------------------
// lpi_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detect and a sideband that travels with each beat.
// ----------------------------------------------------------------------------
module lpi_div #(
  parameter int unsigned QW     = 32,
  parameter int unsigned NW     = 67,
  parameter int unsigned DW     = 116,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW-1:0]     num_i,
  input  logic [NW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quot_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [0:QW];
  logic [DW-1:0]     r_q    [0:QW];
  logic [NW-1:0]     d_q    [0:QW];
  logic [QW-1:0]     q_q    [0:QW];
  logic              o_q    [0:QW];
  logic [SIDE_W-1:0] side_q [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= QW; k++) v_q[k] <= v_q[k-1];
    end
  end

  // stage 0: quotient beyond QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= num_i;
      d_q[0]    <= den_i;
      q_q[0]    <= '0;
      o_q[0]    <= (num_i >= (DW'(den_i) << QW));
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW-1:0] dsh;
    logic          ge;
    assign dsh = DW'(d_q[k-1]) << (QW - k);
    assign ge  = (r_q[k-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? (r_q[k-1] - dsh) : r_q[k-1];
        d_q[k]    <= d_q[k-1];
        q_q[k]    <= q_q[k-1] | (QW'(ge) << (QW - k));
        o_q[k]    <= o_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = q_q[QW];
  assign ovf_o   = o_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== rtl/line_plane_intersect_core.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersect_core
// Intersection of a segment with a configured plane, signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one segment per cycle while the output is not stalled. The
// divider for t resolves one quotient bit per stage. A stall on the output
// freezes the whole pipe. Write the plane only while the pipe is empty; the
// config port is always ready.
module line_plane_intersect_core
  import lpi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] param_t_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o,
  output logic                          parallel_o,
  output logic                          saturated_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned DFW    = W + 1;
  localparam int unsigned PW     = 2 * W + 1;
  localparam int unsigned NW     = 2 * W + 3;
  localparam int unsigned DW     = NW + W + F + 1;
  localparam int unsigned SW     = PW + 1;
  localparam int unsigned SIDE_W = 3 * W + 3 * DFW + 2;

  // config
  logic signed [W-1:0] p_q [0:2];
  logic signed [W-1:0] n_q [0:2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q[0] <= '0;
      p_q[1] <= '0;
      p_q[2] <= '0;
      n_q[0] <= '0;
      n_q[1] <= '0;
      n_q[2] <= W'(1) << F;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PX:  p_q[0] <= cfg_data_i;
        REG_PY:  p_q[1] <= cfg_data_i;
        REG_PZ:  p_q[2] <= cfg_data_i;
        REG_NX:  n_q[0] <= cfg_data_i;
        REG_NY:  n_q[1] <= cfg_data_i;
        REG_NZ:  n_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  logic signed [W-1:0] in_a [0:2];
  logic signed [W-1:0] in_b [0:2];
  assign in_a[0] = start_x_i;
  assign in_a[1] = start_y_i;
  assign in_a[2] = start_z_i;
  assign in_b[0] = end_x_i;
  assign in_b[1] = end_y_i;
  assign in_b[2] = end_z_i;

  // stage 1: differences
  logic                  s1_v_q;
  logic signed [W-1:0]   s1_a_q  [0:2];
  logic signed [DFW-1:0] s1_d_q  [0:2];
  logic signed [DFW-1:0] s1_pa_q [0:2];

  // stage 2: products
  logic                  s2_v_q;
  logic signed [W-1:0]   s2_a_q  [0:2];
  logic signed [DFW-1:0] s2_d_q  [0:2];
  logic signed [PW-1:0]  s2_pn_q [0:2];
  logic signed [PW-1:0]  s2_dn_q [0:2];

  // stage 3: dot sums, sign/magnitude
  logic                  s3_v_q;
  logic signed [W-1:0]   s3_a_q [0:2];
  logic signed [DFW-1:0] s3_d_q [0:2];
  logic [NW-1:0]         s3_nm_q;
  logic [NW-1:0]         s3_dm_q;
  logic                  s3_neg_q;
  logic                  s3_par_q;

  logic signed [NW-1:0] num_s, den_s;
  assign num_s = NW'(s2_pn_q[0]) + NW'(s2_pn_q[1]) + NW'(s2_pn_q[2]);
  assign den_s = NW'(s2_dn_q[0]) + NW'(s2_dn_q[1]) + NW'(s2_dn_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s1_a_q[j]  <= in_a[j];
        s1_d_q[j]  <= DFW'(in_b[j]) - DFW'(in_a[j]);
        s1_pa_q[j] <= DFW'(p_q[j]) - DFW'(in_a[j]);
        s2_a_q[j]  <= s1_a_q[j];
        s2_d_q[j]  <= s1_d_q[j];
        s2_pn_q[j] <= PW'(s1_pa_q[j]) * PW'(n_q[j]);
        s2_dn_q[j] <= PW'(s1_d_q[j]) * PW'(n_q[j]);
        s3_a_q[j]  <= s2_a_q[j];
        s3_d_q[j]  <= s2_d_q[j];
      end
      s3_nm_q  <= num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
      s3_dm_q  <= den_s[NW-1] ? NW'(-den_s) : NW'(den_s);
      s3_neg_q <= num_s[NW-1] ^ den_s[NW-1];
      s3_par_q <= (den_s == '0);
    end
  end

  // divider for t
  logic [SIDE_W-1:0] side_in, side_out;
  logic              dv_v;
  logic [W-1:0]      dv_q;
  logic              dv_ovf;
  logic [DW-1:0]     dv_num;
  logic [NW-1:0]     dv_den;

  assign side_in = {s3_a_q[0], s3_a_q[1], s3_a_q[2],
                    s3_d_q[0], s3_d_q[1], s3_d_q[2], s3_neg_q, s3_par_q};
  assign dv_num  = DW'(s3_nm_q) << F;
  assign dv_den  = s3_par_q ? NW'(1) : s3_dm_q;

  lpi_div #(
    .QW     (W),
    .NW     (NW),
    .DW     (DW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .side_i  (side_in),
    .valid_o (dv_v),
    .quot_o  (dv_q),
    .ovf_o   (dv_ovf),
    .side_o  (side_out)
  );

  logic signed [W-1:0]   dv_a [0:2];
  logic signed [DFW-1:0] dv_d [0:2];
  logic                  dv_neg, dv_par;
  assign {dv_a[0], dv_a[1], dv_a[2], dv_d[0], dv_d[1], dv_d[2], dv_neg, dv_par} = side_out;

  // stage T: saturate t
  logic signed [W-1:0] t_d;
  logic                tsat_d;
  always_comb begin
    t_d    = '0;
    tsat_d = 1'b0;
    if (!dv_par) begin
      if (!dv_neg) begin
        if (dv_ovf || dv_q[W-1]) begin
          t_d    = {1'b0, {(W-1){1'b1}}};
          tsat_d = 1'b1;
        end else begin
          t_d = dv_q;
        end
      end else begin
        if (dv_ovf || (dv_q[W-1] && (dv_q[W-2:0] != '0))) begin
          t_d    = {1'b1, {(W-1){1'b0}}};
          tsat_d = 1'b1;
        end else begin
          t_d = -dv_q;
        end
      end
    end
  end

  logic                  st_v_q;
  logic signed [W-1:0]   st_t_q;
  logic                  st_sat_q, st_par_q;
  logic signed [W-1:0]   st_a_q [0:2];
  logic signed [DFW-1:0] st_d_q [0:2];

  // stage M: step products
  logic                  sm_v_q;
  logic signed [W-1:0]   sm_t_q;
  logic                  sm_sat_q, sm_par_q;
  logic signed [W-1:0]   sm_a_q [0:2];
  logic signed [PW-1:0]  sm_p_q [0:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= 1'b0;
      sm_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      st_v_q  <= dv_v;
      sm_v_q  <= st_v_q;
      out_v_q <= sm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_t_q   <= t_d;
      st_sat_q <= tsat_d;
      st_par_q <= dv_par;
      sm_t_q   <= st_t_q;
      sm_sat_q <= st_sat_q;
      sm_par_q <= st_par_q;
      for (int j = 0; j < 3; j++) begin
        st_a_q[j] <= dv_a[j];
        st_d_q[j] <= dv_d[j];
        sm_a_q[j] <= st_a_q[j];
        sm_p_q[j] <= PW'(st_d_q[j]) * PW'(st_t_q);
      end
    end
  end

  // stage O: shift toward zero, add, saturate
  logic [PW-1:0]        mag    [0:2];
  logic signed [PW-1:0] step   [0:2];
  logic signed [SW-1:0] sum    [0:2];
  logic signed [W-1:0]  hit_d  [0:2];
  logic [2:0]           hsat;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j]  = sm_p_q[j][PW-1] ? PW'(-sm_p_q[j]) : PW'(sm_p_q[j]);
      step[j] = sm_p_q[j][PW-1] ? -$signed(mag[j] >> F) : $signed(mag[j] >> F);
      sum[j]  = SW'(sm_a_q[j]) + SW'(step[j]);
      hsat[j] = 1'b0;
      if (sum[j] > SW'($signed({1'b0, {(W-1){1'b1}}}))) begin
        hit_d[j] = {1'b0, {(W-1){1'b1}}};
        hsat[j]  = 1'b1;
      end else if (sum[j] < SW'($signed({1'b1, {(W-1){1'b0}}}))) begin
        hit_d[j] = {1'b1, {(W-1){1'b0}}};
        hsat[j]  = 1'b1;
      end else begin
        hit_d[j] = sum[j][W-1:0];
      end
    end
  end

  logic signed [W-1:0] o_t_q, o_x_q, o_y_q, o_z_q;
  logic                o_par_q, o_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_par_q <= sm_par_q;
      if (sm_par_q) begin
        o_t_q   <= '0;
        o_x_q   <= '0;
        o_y_q   <= '0;
        o_z_q   <= '0;
        o_sat_q <= 1'b0;
      end else begin
        o_t_q   <= sm_t_q;
        o_x_q   <= hit_d[0];
        o_y_q   <= hit_d[1];
        o_z_q   <= hit_d[2];
        o_sat_q <= sm_sat_q || (hsat != '0);
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign param_t_o   = o_t_q;
  assign hit_x_o     = o_x_q;
  assign hit_y_o     = o_y_q;
  assign hit_z_o     = o_z_q;
  assign parallel_o  = o_par_q;
  assign saturated_o = o_sat_q;

endmodule

// ===== rtl/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// lpi_checker
// Port-level checks of the line/plane intersection core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpi_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [COORD_WIDTH-1:0] param_t_o,
  input logic [COORD_WIDTH-1:0] hit_x_o,
  input logic [COORD_WIDTH-1:0] hit_y_o,
  input logic [COORD_WIDTH-1:0] hit_z_o,
  input logic                   parallel_o,
  input logic                   saturated_o
);

  // parallel beats carry all-zero results
  `LPI_ASSERT(a_par_zero, out_valid_o && parallel_o |-> param_t_o == '0 && hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0 && !saturated_o)

  // input stalls only behind a stalled output beat
  `LPI_ASSERT(a_stall_src, in_stall_o |-> out_valid_o && out_stall_i)

  // a stalled output beat holds
  `LPI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(param_t_o) && $stable(hit_x_o) && $stable(saturated_o))

endmodule

bind line_plane_intersect_core lpi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lpi_checker (.*);
